[design/csf_pkg.sv]
// ----------------------------------------------------------------------------
// Case-insensitive substring finder: shared definitions
// Register map, input operation codes and the ASCII case-folding function.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

    // Pattern storage is fixed at two 64-bit registers.
    localparam int PATTERN_BYTES = 16;
    localparam int PIDX_W        = 4;
    localparam int LEN_W         = 5;

    // Configuration port geometry: 64-bit registers at byte addresses 8*i.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // Register indexes, taken from paddr[4:3].
    typedef enum logic [1:0] {
        REG_LENGTH    = 2'd0,
        REG_PAT_LOW   = 2'd1,
        REG_PAT_HIGH  = 2'd2
    } reg_idx_t;

    // Input operation codes.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Fold ASCII upper case to lower case; all other bytes pass unchanged.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/case_insensitive_substring_finder.sv]
// ----------------------------------------------------------------------------
// Case-insensitive substring finder
// Streams text bytes and end-of-line markers, reporting each leftmost,
// non-overlapping match of the configured pattern as line and start offset.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) carries one item per transaction: a text
// byte of the current line, or an end-of-line marker. The result channel
// (m_valid/m_ready) carries one transaction per match, holding the line index
// and the byte offset where the match starts, both saturating.
// The APB port holds the pattern length (address 0) and the pattern bytes
// (addresses 8 and 16); write it only while no items are in flight.
// An accepted transaction enters the input register; the compare stage then
// registers its result into the result register, which drives m_valid.
// The compare stage matches the shifted window against the pattern in
// parallel, so one item is accepted every cycle while no result is stalled.
// If the receiver stalls with a result pending, the item in the input
// register waits and s_ready drops once that register is full too; nothing
// is lost. Synchronous active-low reset clears the pattern, the window count,
// the line and byte counters and both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_substring_finder #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // Input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [7:0]                    s_text_byte,

    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [LINE_BITS-1:0]               m_line_index,
    output logic [OFFSET_BITS-1:0]             m_start_offset,

    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [csf_pkg::DATA_W-1:0]    pwdata,
    output logic [csf_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W   = (CNT_W > csf_pkg::LEN_W) ? CNT_W : csf_pkg::LEN_W;
    localparam int LIMIT   = (MAX_PATTERN < csf_pkg::PATTERN_BYTES) ?
                             MAX_PATTERN : csf_pkg::PATTERN_BYTES;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [CNT_W-1:0]       CNT_MAX  = CNT_W'(MAX_PATTERN);

    // Configuration registers.
    logic [csf_pkg::LEN_W-1:0]  len_reg;
    logic [63:0]                pat_low_reg;
    logic [63:0]                pat_high_reg;

    // Input register.
    logic                       in_vld_reg;
    logic                       in_op_reg;
    logic [7:0]                 in_byte_reg;

    // Line scan state.
    logic [7:0]                 win_reg [MAX_PATTERN];
    logic [CNT_W-1:0]           cnt_reg;
    logic [LINE_BITS-1:0]       line_reg;
    logic [OFFSET_BITS-1:0]     pos_reg;

    // Result register.
    logic                       out_vld_reg;
    logic [LINE_BITS-1:0]       out_line_reg;
    logic [OFFSET_BITS-1:0]     out_off_reg;

    // Combinational stage signals.
    logic                       advance;
    logic                       cfg_wr;
    csf_pkg::reg_idx_t          cfg_idx;
    logic [7:0]                 win_shift [MAX_PATTERN];
    logic [CNT_W-1:0]           cnt_next;
    logic [CMP_W-1:0]           len_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic [127:0]               pat_all;
    logic                       hit;
    logic [OFFSET_BITS-1:0]     off_calc;

    // The compare stage moves when it holds an item and the result slot is free or being handed over.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid        = out_vld_reg;
    assign m_line_index   = out_line_reg;
    assign m_start_offset = out_off_reg;

    // APB decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = csf_pkg::reg_idx_t'(paddr[4:3]);

    always_comb begin
        unique case (cfg_idx)
            csf_pkg::REG_LENGTH:   prdata = csf_pkg::DATA_W'(len_reg);
            csf_pkg::REG_PAT_LOW:  prdata = pat_low_reg;
            csf_pkg::REG_PAT_HIGH: prdata = pat_high_reg;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                csf_pkg::REG_LENGTH:   len_reg      <= pwdata[csf_pkg::LEN_W-1:0];
                csf_pkg::REG_PAT_LOW:  pat_low_reg  <= pwdata;
                csf_pkg::REG_PAT_HIGH: pat_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Input register: holds the folded byte until the compare stage takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_byte_reg <= csf_pkg::fold(s_text_byte);
        end
    end

    // Window after shifting in the current byte, newest at position zero.
    always_comb begin
        win_shift[0] = in_byte_reg;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_shift[j] = win_reg[j-1];
        end
    end

    assign cnt_next = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + CNT_W'(1);
    assign len_ext  = CMP_W'(len_reg);
    assign cnt_ext  = CMP_W'(cnt_next);
    assign pat_all  = {pat_high_reg, pat_low_reg};

    // Parallel compare: window position j holds pattern byte len-1-j.
    always_comb begin
        logic [CMP_W-1:0]        pidx_full;
        logic [csf_pkg::PIDX_W-1:0] pidx;
        hit = (len_ext != '0) && (len_ext <= CMP_W'(LIMIT)) && (cnt_ext >= len_ext);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pidx_full = len_ext - CMP_W'(j) - CMP_W'(1);
            pidx      = pidx_full[csf_pkg::PIDX_W-1:0];
            if (CMP_W'(j) < len_ext) begin
                if (csf_pkg::fold(pat_all[8*pidx +: 8]) != win_shift[j]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // Start offset is taken from the position before this byte.
    assign off_calc = (pos_reg == OFF_MAX) ? OFF_MAX :
                      pos_reg + OFFSET_BITS'(1) - OFFSET_BITS'(len_reg);

    // Scan state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            line_reg    <= '0;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= '0;
            end
        end else begin
            // The result slot refills on a match and empties on a handshake.
            if (advance && (in_op_reg == csf_pkg::OP_TEXT) && hit) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (advance) begin
                if (in_op_reg == csf_pkg::OP_EOL) begin
                    cnt_reg <= '0;
                    pos_reg <= '0;
                    if (line_reg != LINE_MAX) begin
                        line_reg <= line_reg + LINE_BITS'(1);
                    end
                end else begin
                    for (int j = 0; j < MAX_PATTERN; j++) begin
                        win_reg[j] <= win_shift[j];
                    end
                    if (pos_reg != OFF_MAX) begin
                        pos_reg <= pos_reg + OFFSET_BITS'(1);
                    end
                    // A match empties the window count so matches never overlap.
                    cnt_reg <= hit ? '0 : cnt_next;
                    if (hit) begin
                        out_line_reg <= line_reg;
                        out_off_reg  <= off_calc;
                    end
                end
            end
        end
    end

    // A stalled result with a full input register must block new transactions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |-> !s_ready)
        else $error("input accepted while compare stage is blocked");

    // A match requires an enabled pattern.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == csf_pkg::OP_TEXT && hit |-> len_reg != '0)
        else $error("match reported with zero pattern length");

    // End of line clears the window count and byte position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == csf_pkg::OP_EOL |=> cnt_reg == '0 && pos_reg == '0)
        else $error("line state not cleared at end of line");

    // A pending result never starts beyond the current line position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_off_reg <= pos_reg)
        else $error("result offset beyond current byte position");

endmodule

`default_nettype wire

[sim/csf_match_tracker_pkg.sv]
// ----------------------------------------------------------------------------
// Match tracker for the case-insensitive substring finder testbench
// Follows the text stream item by item, keeps the expected matches in
// arrival order and compares each match that the block reports.
// ----------------------------------------------------------------------------
package csf_match_tracker_pkg;

    // Index that the register map leaves unused; writes to it must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int WINDOW_DEPTH = 16;
    localparam logic [15:0] OFFSET_TOP = 16'hFFFF;
    localparam logic [23:0] LINE_TOP   = 24'hFF_FFFF;

    typedef struct packed {
        logic [23:0] line_index;
        logic [15:0] start_offset;
    } hit_t;

    class match_tracker;
        logic [4:0]  pat_len;
        logic [63:0] pat_low;
        logic [63:0] pat_high;
        logic [7:0]  window [WINDOW_DEPTH];
        int unsigned fill;
        logic [23:0] line_no;
        logic [15:0] byte_pos;
        hit_t        expected_hits [$];
        int          errors;

        function new();
            pat_len  = '0;
            pat_low  = '0;
            pat_high = '0;
            fill     = 0;
            line_no  = '0;
            byte_pos = '0;
            errors   = 0;
            foreach (window[i]) window[i] = 8'h00;
        endfunction

        static function logic [7:0] to_lower(logic [7:0] b);
            if (b >= "A" && b <= "Z") return b + 8'h20;
            return b;
        endfunction

        function logic [7:0] pattern_byte(int k);
            if (k < 8) return pat_low[8*k +: 8];
            return pat_high[8*(k-8) +: 8];
        endfunction

        // Track a register write; indexes outside the map change nothing.
        function void configure(logic [1:0] idx, logic [63:0] value);
            case (idx)
                csf_pkg::REG_LENGTH:   pat_len  = value[4:0];
                csf_pkg::REG_PAT_LOW:  pat_low  = value;
                csf_pkg::REG_PAT_HIGH: pat_high = value;
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < 100) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Advance the line state by one accepted transaction and note any match.
        task take_item(logic op, logic [7:0] text);
            logic [15:0] prev_pos;
            bit          hit;
            hit_t        h;
            if (op == csf_pkg::OP_EOL) begin
                if (line_no != LINE_TOP) line_no++;
                byte_pos = '0;
                fill     = 0;
                return;
            end
            for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = to_lower(text);
            if (fill < WINDOW_DEPTH) fill++;
            prev_pos = byte_pos;
            if (byte_pos != OFFSET_TOP) byte_pos++;

            // The window holds the newest byte first, so pattern byte 0
            // lines up with the oldest of the last pat_len bytes.
            hit = (pat_len != 0) && (pat_len <= WINDOW_DEPTH) && (fill >= pat_len);
            for (int i = 0; hit && i < pat_len; i++) begin
                if (to_lower(pattern_byte(i)) != window[pat_len - 1 - i]) hit = 0;
            end
            if (!hit) return;

            // Emptying the count forces the next match to use fresh bytes only.
            fill = 0;
            h.line_index   = line_no;
            h.start_offset = (prev_pos == OFFSET_TOP) ? OFFSET_TOP
                                                      : prev_pos + 16'd1 - 16'(pat_len);
            expected_hits.push_back(h);
        endtask

        task check_hit(logic [23:0] line, logic [15:0] offset);
            hit_t want;
            if (expected_hits.size() == 0) begin
                report($sformatf("unexpected match at line %0d offset %0d", line, offset));
                return;
            end
            want = expected_hits.pop_front();
            if (line !== want.line_index)
                report($sformatf("line_index %0d, expected %0d", line, want.line_index));
            if (offset !== want.start_offset)
                report($sformatf("start_offset %0d, expected %0d (line %0d)",
                                 offset, want.start_offset, want.line_index));
        endtask

        function int pending();
            return expected_hits.size();
        endfunction

        task report_leftovers();
            foreach (expected_hits[i])
                report($sformatf("missing match at line %0d offset %0d",
                                 expected_hits[i].line_index,
                                 expected_hits[i].start_offset));
        endtask
    endclass

endpackage

[sim/tb_case_insensitive_substring_finder.sv]
// ----------------------------------------------------------------------------
// Testbench for the case-insensitive substring finder
// Programs patterns over APB, streams lines of text with random gaps and
// result stalls, and checks every reported match against a tracked copy of
// the line state, including a full result backlog.
// ----------------------------------------------------------------------------
module tb_case_insensitive_substring_finder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 20;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_operation;
    logic [7:0]                 s_text_byte;
    logic                       m_valid;
    logic                       m_ready;
    logic [23:0]                m_line_index;
    logic [15:0]                m_start_offset;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [csf_pkg::ADDR_W-1:0] paddr;
    logic [csf_pkg::DATA_W-1:0] pwdata;
    logic [csf_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    csf_match_tracker_pkg::match_tracker tracker;
    bit           tx_steady;
    bit           rx_steady;
    int           rx_hold;
    int           stall_left;
    logic [7:0]   cur_pat [16];
    int           cur_len;
    int           random_items;

    case_insensitive_substring_finder #(
        .MAX_PATTERN(16),
        .OFFSET_BITS(16),
        .LINE_BITS  (24)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_text_byte   (s_text_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_index  (m_line_index),
        .m_start_offset(m_start_offset),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mostly back to back, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] mangle_case(logic [7:0] b);
        if (((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) && $urandom_range(0, 1))
            return b ^ 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 1)) return mangle_case(cur_pat[$urandom_range(0, 15)]);
        return 8'($urandom);
    endfunction

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every result transaction is checked against the oldest expected match.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            tracker.check_hit(m_line_index, m_start_offset);
    end

    // Offer one input transaction and hold it until accepted.
    // Called and returning just after a falling edge.
    task automatic send_item(logic op, logic [7:0] text);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_text_byte <= text;
        do @(posedge aclk); while (!s_ready);
        tracker.take_item(op, text);
        @(negedge aclk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(csf_pkg::OP_TEXT, s[i]);
    endtask

    // One APB transfer: setup phase, access phase, then back to idle with psel low.
    task automatic apb_access(logic [1:0] idx, bit is_write, logic [63:0] data,
                              output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (is_write) tracker.configure(idx, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Let the block drain: no valid input, no expected match outstanding,
    // then a settling wait for items that produce nothing.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write cur_pat and the given length word, then read all three back.
    task automatic program_pattern(logic [63:0] len_word);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] rd;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = cur_pat[k];
            hi[8*k +: 8] = cur_pat[k+8];
        end
        if ($urandom_range(0, 1)) begin
            apb_access(csf_pkg::REG_LENGTH, 1'b1, len_word, rd);
            apb_access(csf_pkg::REG_PAT_LOW, 1'b1, lo, rd);
            apb_access(csf_pkg::REG_PAT_HIGH, 1'b1, hi, rd);
        end else begin
            apb_access(csf_pkg::REG_PAT_HIGH, 1'b1, hi, rd);
            apb_access(csf_pkg::REG_PAT_LOW, 1'b1, lo, rd);
            apb_access(csf_pkg::REG_LENGTH, 1'b1, len_word, rd);
        end
        if ($urandom_range(0, 3) == 0)
            apb_access(csf_match_tracker_pkg::REG_SPARE, 1'b1, {$urandom, $urandom}, rd);

        apb_access(csf_pkg::REG_LENGTH, 1'b0, '0, rd);
        if (rd[4:0] !== tracker.pat_len)
            tracker.report($sformatf("length reads %0d, expected %0d",
                                     rd[4:0], tracker.pat_len));
        apb_access(csf_pkg::REG_PAT_LOW, 1'b0, '0, rd);
        if (rd !== tracker.pat_low)
            tracker.report($sformatf("pattern_low reads %h, expected %h", rd, tracker.pat_low));
        apb_access(csf_pkg::REG_PAT_HIGH, 1'b0, '0, rd);
        if (rd !== tracker.pat_high)
            tracker.report($sformatf("pattern_high reads %h, expected %h",
                                     rd, tracker.pat_high));
    endtask

    // Random text built mostly from whole or broken copies of the pattern.
    task automatic run_random_phase(int count);
        int sent;
        int kind;
        int cut;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45 && cur_len >= 1 && cur_len <= 16) begin
                for (int k = 0; k < cur_len; k++)
                    send_item(csf_pkg::OP_TEXT, mangle_case(cur_pat[k]));
                sent += cur_len;
            end else if (kind < 60 && cur_len >= 2 && cur_len <= 16) begin
                cut = $urandom_range(1, cur_len - 1);
                for (int k = 0; k < cut; k++)
                    send_item(csf_pkg::OP_TEXT, mangle_case(cur_pat[k]));
                send_item(csf_pkg::OP_TEXT, pick_byte());
                sent += cut + 1;
            end else if (kind < 88) begin
                send_item(csf_pkg::OP_TEXT, pick_byte());
                sent++;
            end else if (kind < 97) begin
                send_item(csf_pkg::OP_EOL, 8'($urandom));
                sent++;
            end else begin
                send_item(csf_pkg::OP_TEXT, $urandom_range(0, 1) ? 8'h00 : 8'hFF);
                sent++;
            end
        end
        random_items += sent;
    endtask

    // Stimulus sequence.
    initial begin
        logic [63:0] rd;
        int          phase;
        int          mode;
        tracker      = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = csf_pkg::OP_TEXT;
        s_text_byte  = 8'h00;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        rx_hold      = 0;
        random_items = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero length after reset finds nothing.
        send_text("ab");
        wait_idle();

        // Program "AbC" in the middle of the line; the held "ab" completes it.
        apb_access(csf_pkg::REG_LENGTH, 1'b1, 64'd3, rd);
        apb_access(csf_pkg::REG_PAT_LOW, 1'b1, 64'h0000_0000_0043_6241, rd);
        apb_access(csf_pkg::REG_PAT_HIGH, 1'b1, {$urandom, $urandom}, rd);
        send_text("c");
        send_text("xaBc");
        // Back to back matches, then a leftover partial one.
        send_text("abcbc");
        send_item(csf_pkg::OP_EOL, 8'hA5);
        // A match split by an end of line must not be found.
        send_text("ab");
        send_item(csf_pkg::OP_EOL, 8'h00);
        send_text("c");
        send_item(csf_pkg::OP_TEXT, 8'h00);
        send_item(csf_pkg::OP_TEXT, 8'hFF);
        send_text("AbC");
        wait_idle();

        // A length beyond the pattern storage never matches.
        apb_access(csf_pkg::REG_LENGTH, 1'b1, 64'd17, rd);
        send_text("abc");
        wait_idle();

        // Upper bits of the length word are dropped; the spare index is ignored.
        apb_access(csf_pkg::REG_LENGTH, 1'b1, 64'h0000_0001_0000_0003, rd);
        apb_access(csf_match_tracker_pkg::REG_SPARE, 1'b1, 64'd0, rd);
        send_text("abc");
        wait_idle();

        // Backlog: the receiver holds off while every byte matches, so the
        // block fills and must stall its input without losing anything.
        foreach (cur_pat[k]) cur_pat[k] = 8'($urandom);
        cur_pat[0] = "z";
        program_pattern(64'd1);
        tx_steady = 1'b1;
        @(posedge aclk);
        rx_hold = 300;
        @(negedge aclk);
        for (int i = 0; i < 80; i++) send_item(csf_pkg::OP_TEXT, "Z");
        wait_idle();
        tx_steady = 1'b0;

        // Random phases, each with a fresh pattern programmed while idle.
        phase = 0;
        while (random_items < 780) begin
            case (phase)
                0:       cur_len = 1;
                1:       cur_len = 16;
                2:       cur_len = 0;
                3:       cur_len = 17;
                4:       cur_len = 31;
                5:       cur_len = 2;
                default: cur_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(1, 16);
            endcase
            mode = $urandom_range(0, 2);
            foreach (cur_pat[k]) begin
                case (mode)
                    0:       cur_pat[k] = $urandom_range(0, 1) ? "a" : "b";
                    1:       cur_pat[k] = 8'("a" + $urandom_range(0, 25));
                    default: cur_pat[k] = 8'($urandom);
                endcase
                cur_pat[k] = mangle_case(cur_pat[k]);
            end
            rd = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
            rd[4:0] = 5'(cur_len);
            program_pattern(rd);

            // Every sixth phase runs with neither side idling.
            tx_steady = (phase % 6 == 5);
            rx_steady = (phase % 6 == 5);
            run_random_phase($urandom_range(40, 110));
            wait_idle();
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            phase++;
        end

        // Drain with a bound, then settle and report.
        s_valid <= 1'b0;
        for (int k = 0; k < 5000 && tracker.pending() != 0; k++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        tracker.report_leftovers();
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
design/csf_pkg.sv
design/case_insensitive_substring_finder.sv
sim/csf_match_tracker_pkg.sv
sim/tb_case_insensitive_substring_finder.sv
